[hdl/fct_pkg.sv]
`default_nettype none
package fct_pkg;
    localparam int DefPlanes = 6;
    localparam int CoordW    = 24;
    localparam int NormW     = 16;
    localparam int ProdW     = 40;
    localparam int DistW     = 44;

    typedef enum logic [2:0] {
        ACT_BOX_ISECT   = 3'd0,
        ACT_BOX_CONTAIN = 3'd1,
        ACT_POINT       = 3'd2,
        ACT_SPHERE      = 3'd3,
        ACT_LOAD        = 3'd4
    } t_action;

    typedef struct packed {
        logic signed [NormW-1:0]  nx;
        logic signed [NormW-1:0]  ny;
        logic signed [NormW-1:0]  nz;
        logic signed [CoordW-1:0] d;
    } t_plane;

    typedef struct packed {
        logic       vld;
        logic [2:0] act;
    } t_ctl;
endpackage
`default_nettype wire

[hdl/fct_plane_eval.sv]
`default_nettype none
// Evaluate one plane against eight box corners (or a center) over three stages.
// Outputs per-plane "all corners out" and "any corner out".
module fct_plane_eval (
    input  wire logic                        i_clk,
    input  wire fct_pkg::t_plane             i_plane,
    input  wire logic signed [fct_pkg::CoordW-1:0] i_lo [3],
    input  wire logic signed [fct_pkg::CoordW-1:0] i_hi [3],
    input  wire logic signed [fct_pkg::CoordW-1:0] i_rad,
    input  wire logic                        i_sphere,
    output logic                             o_all_out,
    output logic                             o_any_out
);
    import fct_pkg::*;

    // stage 1: six products, one per axis per bound
    logic signed [ProdW-1:0] r_plo [3];
    logic signed [ProdW-1:0] r_phi [3];
    logic signed [DistW-1:0] r_off;
    logic signed [NormW-1:0] nv [3];
    assign nv[0] = i_plane.nx;
    assign nv[1] = i_plane.ny;
    assign nv[2] = i_plane.nz;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_plo[a] <= ProdW'(nv[a] * i_lo[a]);
            r_phi[a] <= ProdW'(nv[a] * i_hi[a]);
        end
        // sphere: test d + r >= -n.p, fold radius into the offset
        r_off <= (DistW'(i_plane.d) + (i_sphere ? DistW'(i_rad) : DistW'(0))) <<< 14;
    end

    // stage 2: partial sums of x and y terms for the four xy corners
    logic signed [DistW-1:0] r_xy [4];
    logic signed [DistW-1:0] r_zl, r_zh;
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_xy[c] <= DistW'(c[0] ? r_phi[0] : r_plo[0])
                     + DistW'(c[1] ? r_phi[1] : r_plo[1]) + r_off;
        end
        r_zl <= DistW'(r_plo[2]);
        r_zh <= DistW'(r_phi[2]);
    end

    // stage 3: eight corner distances and sign reduction
    logic [7:0] neg;
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            neg[c] = (r_xy[c[1:0]] + (c[2] ? r_zh : r_zl)) < 0;
        end
    end
    always_ff @(posedge i_clk) begin
        o_all_out <= &neg;
        o_any_out <= |neg;
    end
endmodule
`default_nettype wire

[hdl/frustum_culling_test_top.sv]
`default_nettype none
// Channel  | Ports                                          | Handshake
// input    | i_action .. i_normal_z                         | i_start && !o_busy
// result   | o_hit                                          | o_done strobe
// o_done follows the control stages r_ctl[0..2]; one item enters per cycle.
// o_busy is always low: all planes are evaluated in parallel lanes.
// Reset i_rst_n is synchronous, active low; it clears the valid pipeline.
// Plane table is undefined until loaded. The receiver cannot stall.
module frustum_culling_test_top #(
    parameter int PLANES = fct_pkg::DefPlanes
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [2:0]  i_plane_index,
    input  wire logic signed [23:0] i_min_x,
    input  wire logic signed [23:0] i_min_y,
    input  wire logic signed [23:0] i_min_z,
    input  wire logic signed [23:0] i_max_x,
    input  wire logic signed [23:0] i_max_y,
    input  wire logic signed [23:0] i_max_z,
    input  wire logic signed [23:0] i_scalar,
    input  wire logic signed [15:0] i_normal_x,
    input  wire logic signed [15:0] i_normal_y,
    input  wire logic signed [15:0] i_normal_z,
    output logic             o_done,
    output logic             o_hit
);
    import fct_pkg::*;

    assign o_busy = 1'b0;
    logic acc;
    assign acc = i_start;

    // plane table, one register per slot
    t_plane r_planes [PLANES];
    always_ff @(posedge i_clk) begin
        if (acc && i_action == ACT_LOAD && 32'(i_plane_index) < PLANES) begin
            r_planes[i_plane_index] <= '{i_normal_x, i_normal_y, i_normal_z, i_scalar};
        end
    end

    logic signed [CoordW-1:0] lo [3];
    logic signed [CoordW-1:0] hi [3];
    logic                     is_box;
    assign is_box = i_action == ACT_BOX_ISECT || i_action == ACT_BOX_CONTAIN;
    assign lo[0] = i_min_x;
    assign lo[1] = i_min_y;
    assign lo[2] = i_min_z;
    // non-box shapes use the center for every corner
    assign hi[0] = is_box ? i_max_x : i_min_x;
    assign hi[1] = is_box ? i_max_y : i_min_y;
    assign hi[2] = is_box ? i_max_z : i_min_z;

    logic [PLANES-1:0] all_out, any_out;
    for (genvar k = 0; k < PLANES; k++) begin : g_lane
        fct_plane_eval u_eval (
            .i_clk    (i_clk),
            .i_plane  (r_planes[k]),
            .i_lo     (lo),
            .i_hi     (hi),
            .i_rad    (i_scalar),
            .i_sphere (i_action == ACT_SPHERE),
            .o_all_out(all_out[k]),
            .o_any_out(any_out[k])
        );
    end

    // control pipeline matching the three lane stages
    t_ctl r_ctl [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) r_ctl[s] <= '0;
        end else begin
            r_ctl[0] <= '{acc && i_action < ACT_LOAD, i_action};
            r_ctl[1] <= r_ctl[0];
            r_ctl[2] <= r_ctl[1];
        end
    end

    // combine lanes into the final verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_ctl[2].vld;
        end
        if (r_ctl[2].act == ACT_BOX_CONTAIN) begin
            o_hit <= ~|any_out;
        end else begin
            o_hit <= ~|all_out;
        end
    end

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[2].vld |=> o_done) else $error("lost result");
    a_no_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_action == ACT_LOAD) |=> !r_ctl[0].vld) else $error("load gave result");
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_ctl[2].vld)) else $error("invented result");
endmodule
`default_nettype wire
